FILE: hdl/cv3_pkg.sv
// Shared types, widths and helpers of the 3x3 valid-region convolution block.
package cv3_pkg;

    localparam int MAX_SIZE     = 1024;
    localparam int ADDR_W       = $clog2(MAX_SIZE);
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ROW_W        = PROD_W + 2;
    localparam int FILT_W       = 35;
    localparam int SIZE_W       = 11;
    localparam int KROW_W       = 3 * COEF_W;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 40;
    localparam int MIN_SIZE     = 3;
    localparam int WIN_FIRST    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP    = 2'd0,
        REG_KERNEL_MIDDLE = 2'd1,
        REG_KERNEL_BOTTOM = 2'd2,
        REG_IMAGE_SIZE    = 2'd3
    } cv3_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [2:0][KROW_W-1:0]     cv3_kernel_t;
    typedef logic signed [FILT_W-1:0]   filt_t;

    typedef struct packed {
        logic produce;
        logic last;
    } cv3_tag_t;

    typedef struct packed {
        logic shift_en;
        logic prod_en;
        logic row_en;
        logic sum_en;
    } cv3_adv_t;

    function automatic logic [ADDR_W-1:0] size_last(input logic [SIZE_W-1:0] size);
        logic [ADDR_W-1:0] res;
        if (size < SIZE_W'(MIN_SIZE))
            res = ADDR_W'(MIN_SIZE - 1);
        else if (size > SIZE_W'(MAX_SIZE))
            res = ADDR_W'(MAX_SIZE - 1);
        else
            res = ADDR_W'(size - SIZE_W'(1));
        return res;
    endfunction

endpackage

FILE: hdl/cv3_line_buf.sv
// Two line stores holding the previous two image rows, registered read.
module cv3_line_buf (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [cv3_pkg::ADDR_W-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [cv3_pkg::ADDR_W-1:0] wr_addr,
    input  cv3_pkg::sample_t         wr_upper,
    input  cv3_pkg::sample_t         wr_middle,
    output cv3_pkg::sample_t         rd_upper,
    output cv3_pkg::sample_t         rd_middle
);
    import cv3_pkg::*;

    sample_t upper_mem  [MAX_SIZE];
    sample_t middle_mem [MAX_SIZE];
    sample_t rd_upper_reg;
    sample_t rd_middle_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            rd_upper_reg  <= upper_mem[rd_addr];
            rd_middle_reg <= middle_mem[rd_addr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

FILE: hdl/cv3_mac.sv
// 3x3 window, nine coefficient products, row sums and final sum register.
module cv3_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cv3_pkg::cv3_adv_t    adv,
    input  cv3_pkg::sample_t     new_upper,
    input  cv3_pkg::sample_t     new_middle,
    input  cv3_pkg::sample_t     new_sample,
    input  cv3_pkg::cv3_kernel_t kernel,
    output cv3_pkg::filt_t       filtered
);
    import cv3_pkg::*;

    sample_t                   window_reg [3][3];
    logic signed [PROD_W-1:0]  prod_reg   [3][3];
    logic signed [PROD_W-1:0]  prod_next  [3][3];
    logic signed [ROW_W-1:0]   row_reg    [3];
    logic signed [ROW_W-1:0]   row_next   [3];
    filt_t                     sum_reg;
    filt_t                     sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    window_reg[r][c] <= '0;
        end
        else if (adv.shift_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r][0] <= window_reg[r][1];
                window_reg[r][1] <= window_reg[r][2];
            end
            window_reg[0][2] <= new_upper;
            window_reg[1][2] <= new_middle;
            window_reg[2][2] <= new_sample;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                prod_next[r][c] = PROD_W'(window_reg[r][c])
                                * PROD_W'($signed(kernel[r][c*COEF_W +: COEF_W]));
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            row_next[r] = ROW_W'(prod_reg[r][0]) + ROW_W'(prod_reg[r][1])
                        + ROW_W'(prod_reg[r][2]);
    end

    assign sum_next = FILT_W'(row_reg[0]) + FILT_W'(row_reg[1]) + FILT_W'(row_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv.prod_en)
            prod_reg <= prod_next;
        if (adv.row_en)
            row_reg <= row_next;
        if (adv.sum_en)
            sum_reg <= sum_next;
    end

    assign filtered = sum_reg;

endmodule

FILE: hdl/conv3x3_valid_stream_unit.sv
// Top level of the streaming 3x3 valid-region convolution block.
//
// Usage:
//   s_* carries one signed 16-bit sample per word, raster order, row by row,
//   of a square image of image_size samples a side.
//   m_* carries one 35-bit signed result per word in m_tdata; m_tlast marks
//   the last result of an image, after which the position counters restart.
//   Only windows that lie wholly inside the image give a word, so an image of
//   N samples a side yields (N-2) x (N-2) words.
//   cfg_* writes one register per handshake: index 0..2 are the top, middle
//   and bottom kernel rows (three signed 16-bit coefficients, left lowest),
//   index 3 the image size (clamped to 3..1024). Write only while idle.
// Timing: one word accepted per cycle unless back-pressure from m_tready has filled
//   the pipeline; a result passes the line store read, window, product, row sum
//   and final sum registers before it appears on m_tvalid.
// Reset clears kernel rows, position counters and window; image size is 3.
//   The line stores need no clearing pass.
// When m_tready is low each pipeline stage holds only if the stage after it
//   is full, so empty slots fill up before s_tready drops.
module conv3x3_valid_stream_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cv3_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cv3_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [34:0] filtered, rest zero
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cv3_pkg::KROW_W-1:0]          cfg_data
);
    import cv3_pkg::*;

    cv3_kernel_t        kernel_reg;
    logic [ADDR_W-1:0]  size_last_reg;
    logic [ADDR_W-1:0]  col_reg;
    logic [ADDR_W-1:0]  col_next;
    logic [ADDR_W-1:0]  row_reg;
    logic [ADDR_W-1:0]  row_next;

    logic               v1_reg;
    logic               vw_reg;
    logic               vp_reg;
    logic               vr_reg;
    logic               vo_reg;
    cv3_tag_t           tag1_reg;
    cv3_tag_t           tagw_reg;
    cv3_tag_t           tagp_reg;
    cv3_tag_t           tagr_reg;
    logic               last_o_reg;
    sample_t            s1_sample_reg;
    logic [ADDR_W-1:0]  s1_col_reg;

    logic               en_o;
    logic               en_r;
    logic               en_p;
    logic               en_w;
    logic               en_1;
    logic               accept;
    cv3_tag_t           acc_tag;
    cv3_adv_t           adv;
    sample_t            rd_upper;
    sample_t            rd_middle;
    filt_t              filtered;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg    <= '0;
            size_last_reg <= ADDR_W'(MIN_SIZE - 1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cv3_reg_t'(cfg_index))
                REG_KERNEL_TOP:    kernel_reg[0] <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data;
                REG_IMAGE_SIZE:    size_last_reg <= size_last(cfg_data[SIZE_W-1:0]);
                default:           ;
            endcase
        end
    end

    assign en_o     = !vo_reg || m_tready;
    assign en_r     = !vr_reg || en_o;
    assign en_p     = !vp_reg || en_r;
    assign en_w     = !vw_reg || en_p;
    assign en_1     = !v1_reg || en_w;
    assign s_tready = en_1;
    assign accept   = s_tvalid && en_1;

    assign acc_tag.produce = (row_reg >= ADDR_W'(WIN_FIRST)) && (col_reg >= ADDR_W'(WIN_FIRST));
    assign acc_tag.last    = (row_reg >= size_last_reg) && (col_reg >= size_last_reg);

    always_comb
    begin
        if (col_reg >= size_last_reg)
        begin
            col_next = '0;
            row_next = (row_reg >= size_last_reg) ? '0 : row_reg + ADDR_W'(1);
        end
        else
        begin
            col_next = col_reg + ADDR_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            v1_reg     <= 1'b0;
            vw_reg     <= 1'b0;
            vp_reg     <= 1'b0;
            vr_reg     <= 1'b0;
            vo_reg     <= 1'b0;
            tag1_reg   <= '0;
            tagw_reg   <= '0;
            tagp_reg   <= '0;
            tagr_reg   <= '0;
            last_o_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en_1)
            begin
                v1_reg   <= s_tvalid;
                tag1_reg <= acc_tag;
            end
            if (en_w)
            begin
                vw_reg   <= v1_reg;
                tagw_reg <= tag1_reg;
            end
            if (en_p)
            begin
                vp_reg   <= vw_reg;
                tagp_reg <= tagw_reg;
            end
            if (en_r)
            begin
                vr_reg   <= vp_reg;
                tagr_reg <= tagp_reg;
            end
            if (en_o)
            begin
                vo_reg     <= vr_reg && tagr_reg.produce;
                last_o_reg <= tagr_reg.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_t'(s_tdata[SAMPLE_W-1:0]);
            s1_col_reg    <= col_reg;
        end
    end

    assign adv.shift_en = en_w && v1_reg;
    assign adv.prod_en  = en_p && vw_reg;
    assign adv.row_en   = en_r && vp_reg;
    assign adv.sum_en   = en_o && vr_reg && tagr_reg.produce;

    cv3_line_buf u_line_buf (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .wr_en     (adv.shift_en),
        .wr_addr   (s1_col_reg),
        .wr_upper  (rd_middle),
        .wr_middle (s1_sample_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    cv3_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .new_upper  (rd_upper),
        .new_middle (rd_middle),
        .new_sample (s1_sample_reg),
        .kernel     (kernel_reg),
        .filtered   (filtered)
    );

    assign m_tvalid = vo_reg;
    assign m_tlast  = last_o_reg;
    assign m_tdata  = {{(OUT_TDATA_W - FILT_W){1'b0}}, filtered};

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_tag.last) |=> (col_reg == '0) && (row_reg == '0))
        else $error("position counters did not restart after the last window");

    a_no_store_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && adv.shift_en) |-> (s1_col_reg != col_reg))
        else $error("line store read and write hit the same column");

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for conv3x3_valid_stream_unit: streamed images against a window predictor.
`timescale 1ns / 100ps

module tb_top;
    import cv3_pkg::*;

    typedef struct {
        filt_t filtered;
        logic  last;
    } filt_word_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_KERNEL_TOP;
    logic [KROW_W-1:0]      cfg_data  = '0;

    sample_t           line_upper [MAX_SIZE];
    sample_t           line_middle[MAX_SIZE];
    sample_t           win [3][3];
    int                row_pos;
    int                col_pos;
    logic [KROW_W-1:0] kernel_rows [3];
    logic [SIZE_W-1:0] size_reg;
    filt_word_t        pending_filt[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int error_count;
    int samples_sent;

    conv3x3_valid_stream_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** conv3x3_valid_stream_unit: FAILED **");
        $finish;
    end

    function automatic int side_len();
        int s;
        s = int'(size_reg);
        if (s < MIN_SIZE)
            s = MIN_SIZE;
        if (s > MAX_SIZE)
            s = MAX_SIZE;
        return s;
    endfunction

    function automatic sample_t rand_sample();
        sample_t v;
        case ($urandom_range(9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        logic [KROW_W-1:0] row;
        for (int c = 0; c < 3; c++)
            row[COEF_W*c +: COEF_W] = rand_sample();
        return row;
    endfunction

    task automatic predict_window_sum(input sample_t smp);
        int         side;
        int         col;
        longint     acc;
        sample_t    cf;
        filt_word_t res;
        side = side_len();
        col  = col_pos;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = line_upper[col];
        win[1][2] = line_middle[col];
        win[2][2] = smp;
        line_upper[col]  = line_middle[col];
        line_middle[col] = smp;
        if (row_pos >= WIN_FIRST && col >= WIN_FIRST)
        begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    cf = kernel_rows[r][COEF_W*c +: COEF_W];
                    acc += longint'(win[r][c]) * longint'(cf);
                end
            res.filtered = acc[FILT_W-1:0];
            res.last     = (row_pos >= side - 1) && (col >= side - 1);
            pending_filt.push_back(res);
        end
        if (col >= side - 1)
        begin
            col_pos = 0;
            row_pos = (row_pos >= side - 1) ? 0 : row_pos + 1;
        end
        else
            col_pos = col + 1;
    endtask

    task automatic push_sample(input sample_t smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_window_sum(smp);
        samples_sent++;
    endtask

    task automatic finish_image();
        do
            push_sample(rand_sample());
        while (row_pos != 0 || col_pos != 0);
    endtask

    task automatic write_reg(input cv3_reg_t idx, input logic [KROW_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KERNEL_TOP:    kernel_rows[0] = val;
            REG_KERNEL_MIDDLE: kernel_rows[1] = val;
            REG_KERNEL_BOTTOM: kernel_rows[2] = val;
            REG_IMAGE_SIZE:    size_reg = val[SIZE_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_size(input int n);
        logic [KROW_W-1:0] v;
        v = KROW_W'({$urandom, $urandom});
        v[SIZE_W-1:0] = n[SIZE_W-1:0];
        write_reg(REG_IMAGE_SIZE, v);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_filt.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed();
        // ascending coefficients expose any flip of rows or columns
        write_size(0);
        write_reg(REG_KERNEL_TOP,    {16'd3, 16'd2, 16'd1});
        write_reg(REG_KERNEL_MIDDLE, {16'd6, 16'd5, 16'd4});
        write_reg(REG_KERNEL_BOTTOM, {16'd9, 16'd8, 16'd7});
        for (int n = 0; n < 9; n++)
            push_sample(sample_t'(n * 3001 - 12000));
        wait_idle();
        write_reg(REG_KERNEL_TOP,    {3{16'h8000}});
        write_reg(REG_KERNEL_MIDDLE, {3{16'h8000}});
        write_reg(REG_KERNEL_BOTTOM, {3{16'h8000}});
        repeat (9) push_sample(16'h8000);
        wait_idle();
        write_reg(REG_KERNEL_TOP,    {3{16'h7FFF}});
        write_reg(REG_KERNEL_MIDDLE, {3{16'h7FFF}});
        write_reg(REG_KERNEL_BOTTOM, {3{16'h7FFF}});
        repeat (4) push_sample(16'h8000);
        push_sample(16'h7FFF);
        repeat (4) push_sample(16'h8000);
    endtask

    task automatic test_size_limits();
        wait_idle();
        write_reg(REG_KERNEL_TOP,    rand_kernel_row());
        write_reg(REG_KERNEL_MIDDLE, rand_kernel_row());
        write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
        write_size(MAX_SIZE);
        repeat (MAX_SIZE + 6) push_sample(rand_sample());
        // shrink the side mid-image
        wait_idle();
        write_size(4);
        finish_image();
        wait_idle();
        write_size((1 << SIZE_W) - 1);
        repeat (5) push_sample(rand_sample());
        wait_idle();
        write_size(4);
        finish_image();
        // end the image early: the current row is already past the new side
        wait_idle();
        write_size(8);
        repeat (5 * 8 + 3) push_sample(rand_sample());
        wait_idle();
        write_size(4);
        finish_image();
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(5);
        hold_left = 80;
        repeat (3 * 25) push_sample(rand_sample());
        wait_idle();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int quota);
        int start;
        int side;
        int images;
        start = samples_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (samples_sent - start < quota)
        begin
            wait_idle();
            if ($urandom_range(1))
                write_reg(REG_KERNEL_TOP, rand_kernel_row());
            if ($urandom_range(1))
                write_reg(REG_KERNEL_MIDDLE, rand_kernel_row());
            if ($urandom_range(1))
                write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
            case ($urandom_range(9))
                0: side = $urandom_range(0, 2);
                1: side = $urandom_range(13, 20);
                default: side = $urandom_range(3, 8);
            endcase
            write_size(side);
            images = $urandom_range(1, 3);
            for (int i = 0; i < images; i++)
            begin
                if (i == images - 1 && $urandom_range(5) == 0)
                begin
                    repeat ($urandom_range(1, side_len() * side_len() - 1))
                        push_sample(rand_sample());
                    wait_idle();
                    write_size($urandom_range(0, side_len()));
                end
                finish_image();
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        filt_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_filt.size() == 0)
            begin
                $display("%0t unexpected word: got %0d last %0b", $time,
                         $signed(m_tdata[FILT_W-1:0]), m_tlast);
                error_count++;
            end
            else
            begin
                want = pending_filt.pop_front();
                if (m_tdata !== {{(OUT_TDATA_W-FILT_W){1'b0}}, want.filtered})
                begin
                    $display("%0t filtered mismatch: expected %0d, got %0d (word %h)", $time,
                             want.filtered, $signed(m_tdata[FILT_W-1:0]), m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t last mismatch: expected %0b, got %0b", $time,
                             want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            line_upper[i]  = '0;
            line_middle[i] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            kernel_rows[r] = '0;
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        end
        row_pos       = 0;
        col_pos       = 0;
        size_reg      = SIZE_W'(MIN_SIZE);
        hold_left     = 0;
        error_count   = 0;
        samples_sent  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 81;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_limits();
        test_backpressure();
        test_random_phase(31, 81, 200);
        test_random_phase(81, 31, 200);
        test_random_phase(0, 0, 200);
        wait_idle();

        if (error_count == 0 && pending_filt.size() == 0)
            $display("** conv3x3_valid_stream_unit: PASSED **");
        else
            $display("** conv3x3_valid_stream_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cv3_pkg.sv
hdl/cv3_line_buf.sv
hdl/cv3_mac.sv
hdl/conv3x3_valid_stream_unit.sv
verif/tb_top.sv
